>>> rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, register indexes and the divide-by-nine helper for the
// 3x3 box blur stream unit.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int FIFO_DEPTH = 8;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // ceil(2^16 / 9); exact floor for sums below 2^12
  localparam logic [12:0] DIV9_RECIP = 13'd7282;

  typedef struct packed {
    logic [7:0] two_above;
    logic [7:0] above;
  } line_word_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] col;
    logic [7:0] row_m1;
    logic       has_row;
    logic       top_ok;
    logic       col_first;
    logic       col_last;
    logic       pad_row;
    logic [7:0] bot;
  } tap_t;

  typedef struct packed {
    logic [7:0] blurred;
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

  function automatic logic [7:0] div9(input logic [11:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'(DIV9_RECIP);
    return p[23:16];
  endfunction

endpackage

>>> rtl/core/bb3_line_mem.sv
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store for the two previous rows: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output bb3_pkg::line_word_t  rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  bb3_pkg::line_word_t  wr_data
);

  bb3_pkg::line_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// Column sums of the 3x3 window, the two neighbourhood sums and the
// divide by nine; the sums are registered and divided after the register.
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic                clk,
  input  logic                rst_n,
  input  bb3_pkg::tap_t       tap,
  input  bb3_pkg::line_word_t rdata,
  output bb3_pkg::push_t      push,
  output logic                busy
);

  logic [9:0]  c0_r, c1_r;
  logic [9:0]  c0_nxt, c1_nxt;
  logic [7:0]  top;
  logic [9:0]  cur;
  logic [9:0]  c0_eff, c1_eff;
  logic [11:0] sum0;
  logic [10:0] sum1;

  logic        s2_v_r, s2_e0_r, s2_e1_r;
  logic [11:0] s2_sum0_r;
  logic [10:0] s2_sum1_r;
  logic [7:0]  s2_row_r, s2_col_r;
  logic        s2_last_r;

  always_comb begin
    top    = tap.top_ok ? rdata.two_above : 8'd0;
    cur    = 10'(top) + 10'(rdata.above) + 10'(tap.bot);
    c0_eff = tap.col_first ? 10'd0 : c0_r;
    c1_eff = tap.col_first ? 10'd0 : c1_r;
    sum0   = 12'(c0_eff) + 12'(c1_eff) + 12'(cur);
    sum1   = 11'(c1_eff) + 11'(cur);
    c0_nxt = tap.valid ? c1_eff : c0_r;
    c1_nxt = tap.valid ? cur : c1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r    <= '0;
      c1_r    <= '0;
      s2_v_r  <= 1'b0;
      s2_e0_r <= 1'b0;
      s2_e1_r <= 1'b0;
    end else begin
      c0_r    <= c0_nxt;
      c1_r    <= c1_nxt;
      s2_v_r  <= tap.valid;
      s2_e0_r <= tap.valid & tap.has_row & ~tap.col_first;
      s2_e1_r <= tap.valid & tap.has_row & tap.col_last;
    end
  end

  always_ff @(posedge clk) begin
    if (tap.valid) begin
      s2_sum0_r <= sum0;
      s2_sum1_r <= sum1;
      s2_row_r  <= tap.row_m1;
      s2_col_r  <= tap.col;
      s2_last_r <= tap.pad_row;
    end
  end

  always_comb begin
    push.v0         = s2_e0_r;
    push.r0.blurred = bb3_pkg::div9(s2_sum0_r);
    push.r0.row     = s2_row_r;
    push.r0.col     = s2_col_r - 8'd1;
    push.r0.last    = 1'b0;
    push.v1         = s2_e1_r;
    push.r1.blurred = bb3_pkg::div9(12'(s2_sum1_r));
    push.r1.row     = s2_row_r;
    push.r1.col     = s2_col_r;
    push.r1.last    = s2_last_r;
  end

  assign busy = s2_v_r;

endmodule

>>> rtl/core/bb3_out_fifo.sv
// ----------------------------------------------------------------------------
// bb3_out_fifo
// Result queue: takes up to two items a cycle, gives one a cycle when popped.
// ----------------------------------------------------------------------------
module bb3_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bb3_pkg::push_t        push,
  input  logic                  pop,
  output bb3_pkg::result_t      head,
  output logic                  head_valid,
  output logic [$clog2(bb3_pkg::FIFO_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(bb3_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(bb3_pkg::FIFO_DEPTH + 1);

  bb3_pkg::result_t q_r [bb3_pkg::FIFO_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r, wptr_nxt, rptr_nxt, wsel1;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wsel1     = push.v0 ? wptr_r + PW'(1) : wptr_r;
    wptr_nxt  = wptr_r + PW'(push.v0) + PW'(push.v1);
    rptr_nxt  = rptr_r + PW'(pop);
    count_nxt = count_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_r[wptr_r] <= push.r0;
    end
    if (push.v1) begin
      q_r[wsel1] <= push.r1;
    end
  end

  assign head       = q_r[rptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule

>>> rtl/core/box_blur_3x3_stream_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_unit
// 3x3 mean filter over a raster stream of 8-bit pixels, zero outside the
// image; output row r appears while input row r+1 (or the padding row)
// arrives.
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_stall    in_pixel, in_padding_row
//   out       out   out_valid/out_stall  out_blurred, out_out_row,
//                                        out_out_col, out_frame_last
//   cfg       in    cfg_wr_en            cfg_index, cfg_data
//
// One item per cycle while in_stall is low; a result passes the line store
// read, the window sums and the divide by nine into the result queue.
// The last item of a row after row 0 gives two results; the 8-entry result queue
// absorbs them, so the input stalls only while out_stall holds results back.
// rst_n is synchronous; no clearing pass, line stores are written before read.
// A cfg write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_unit #(
  parameter int MAX_WIDTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixel,
  input  logic       in_padding_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blurred,
  output logic [7:0] out_out_row,
  output logic [7:0] out_out_col,
  output logic       out_frame_last,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int CAP = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int AW  = $clog2(CAP);
  localparam int CW  = $clog2(bb3_pkg::FIFO_DEPTH + 1);
  localparam logic [8:0] CAP9 = 9'(CAP);

  logic [8:0]    width_r, height_r;
  logic [8:0]    w_eff, h_eff;
  logic [AW-1:0] cc_r, cc_nxt;
  logic [8:0]    rr_r, rr_nxt;
  logic          accept, col_last, pad_row;

  bb3_pkg::tap_t       tap_r, tap_nxt;
  bb3_pkg::line_word_t rdata, wdata;
  bb3_pkg::push_t      push;
  bb3_pkg::result_t    head;
  logic                s2_busy, pop;
  logic [CW-1:0]       q_count;

  always_comb begin
    if (width_r < 9'd2) begin
      w_eff = 9'd2;
    end else if (width_r > CAP9) begin
      w_eff = CAP9;
    end else begin
      w_eff = width_r;
    end
    if (height_r < 9'd2) begin
      h_eff = 9'd2;
    end else if (height_r > 9'd256) begin
      h_eff = 9'd256;
    end else begin
      h_eff = height_r;
    end
  end

  assign in_stall = (6'(q_count) + 6'({tap_r.valid, 1'b0}) + 6'({s2_busy, 1'b0}))
                    > 6'(bb3_pkg::FIFO_DEPTH - 2);
  assign accept   = in_valid & ~in_stall;
  assign col_last = (9'(cc_r) == (w_eff - 9'd1));
  assign pad_row  = (rr_r == h_eff);

  always_comb begin
    cc_nxt = cc_r;
    rr_nxt = rr_r;
    if (accept) begin
      if (col_last) begin
        cc_nxt = '0;
        rr_nxt = pad_row ? 9'd0 : rr_r + 9'd1;
      end else begin
        cc_nxt = cc_r + AW'(1);
      end
    end
    if (cfg_wr_en) begin
      cc_nxt = '0;
      rr_nxt = '0;
    end
  end

  always_comb begin
    tap_nxt.valid     = accept;
    tap_nxt.col       = 8'(cc_r);
    tap_nxt.row_m1    = 8'(rr_r - 9'd1);
    tap_nxt.has_row   = (rr_r != 9'd0);
    tap_nxt.top_ok    = (rr_r >= 9'd2);
    tap_nxt.col_first = (cc_r == '0);
    tap_nxt.col_last  = col_last;
    tap_nxt.pad_row   = pad_row;
    tap_nxt.bot       = (in_padding_row | pad_row) ? 8'd0 : in_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 9'd256;
      height_r    <= 9'd256;
      cc_r        <= '0;
      rr_r        <= '0;
      tap_r.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bb3_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_data;
          bb3_pkg::CFG_IDX_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      cc_r  <= cc_nxt;
      rr_r  <= rr_nxt;
      tap_r <= tap_nxt;
    end
  end

  assign wdata.two_above = rdata.above;
  assign wdata.above     = tap_r.bot;

  bb3_line_mem #(
    .DEPTH (CAP),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cc_r),
    .rd_data (rdata),
    .wr_en   (tap_r.valid),
    .wr_addr (tap_r.col[AW-1:0]),
    .wr_data (wdata)
  );

  bb3_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .tap   (tap_r),
    .rdata (rdata),
    .push  (push),
    .busy  (s2_busy)
  );

  assign pop = out_valid & ~out_stall;

  bb3_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .count      (q_count)
  );

  assign out_blurred    = head.blurred;
  assign out_out_row    = head.row;
  assign out_out_col    = head.col;
  assign out_frame_last = head.last;

endmodule

>>> rtl/core/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks for the box blur stream unit, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_blurred,
  input logic [7:0] out_out_row,
  input logic [7:0] out_out_col,
  input logic       out_frame_last
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_blurred)
      && $stable(out_out_row) && $stable(out_out_col) && $stable(out_frame_last))
    else $error("stalled result item changed");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_out_col != 8'd0)
    else $error("frame end flagged on column zero");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_acc) && !$past(in_acc, 2) |=> !out_valid)
    else $error("result item without a preceding input item");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result item right after reset");

endmodule

bind box_blur_3x3_stream_unit bb3_checker u_bb3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_blurred    (out_blurred),
  .out_out_row    (out_out_row),
  .out_out_col    (out_out_col),
  .out_frame_last (out_frame_last)
);
